// File: rtl/core/psk_pkg.sv
// Shared types, constants and lookup tables for the partial-sum key check.
// No dependencies; the cfg interface and all module files use this package.
`timescale 1ns / 1ps

package psk_pkg;

  // Parity store geometry
  localparam int PARITY_ENTRIES = 256;
  localparam int PAR_AW         = $clog2(PARITY_ENTRIES);

  // Front-to-back queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 8;
  localparam logic [CFG_IW-1:0] REG_GUESS_K4   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_GUESS_K5   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ROW_SELECT = 2'd2;

  // Configuration register set
  typedef struct packed {
    logic [7:0] guess_k4;
    logic [7:0] guess_k5;
    logic       row_select;
  } cfg_regs_t;

  // One classified item as it waits in the queue
  typedef struct packed {
    logic [PAR_AW-1:0] pos;
    logic              flip;
    logic              last;
  } qent_t;

  // Status from the back part to the front part
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // First-row table
  localparam logic [7:0] ROW1_TAB [256] = '{
    8'hf4,8'h41,8'h17,8'h27,8'hab,8'h9d,8'hfa,8'he3,8'h30,8'h76,8'hcc,8'h02,8'he5,8'h2a,8'h35,8'h62,
    8'hb1,8'hba,8'hea,8'hfe,8'h2f,8'h4c,8'h46,8'hd3,8'h8f,8'h92,8'h6d,8'h52,8'hbe,8'h74,8'he0,8'hc9,
    8'hc2,8'h8e,8'h58,8'hb9,8'he1,8'h88,8'h20,8'hce,8'hdf,8'h1a,8'h51,8'h53,8'h64,8'h6b,8'h81,8'h08,
    8'h48,8'h45,8'hde,8'h7b,8'h73,8'h4b,8'h1f,8'h55,8'heb,8'hb5,8'hc5,8'h37,8'h28,8'hbf,8'h03,8'h16,
    8'hcf,8'h79,8'h07,8'h69,8'hda,8'h05,8'h34,8'ha6,8'h2e,8'hf3,8'h8a,8'hf6,8'h83,8'h60,8'h71,8'h6e,
    8'h21,8'hdd,8'h3e,8'he6,8'h54,8'hc4,8'h06,8'h50,8'h98,8'hbd,8'h40,8'hd9,8'he8,8'h89,8'h19,8'hc8,
    8'h7c,8'h42,8'h84,8'h00,8'h80,8'h2b,8'h11,8'h5a,8'h0e,8'h85,8'hae,8'h2d,8'h0f,8'h5c,8'h5b,8'h36,
    8'h0a,8'h57,8'hee,8'h9b,8'hc0,8'hdc,8'h77,8'h12,8'h93,8'ha0,8'h22,8'h1b,8'h09,8'h8b,8'hb6,8'h1e,
    8'hf1,8'h75,8'h99,8'h7f,8'h01,8'h72,8'h66,8'hfb,8'h43,8'h23,8'hed,8'he4,8'h31,8'h63,8'h97,8'hc6,
    8'h4a,8'hbb,8'hf9,8'h29,8'h9e,8'hb2,8'h86,8'hc1,8'hb3,8'h70,8'h94,8'he9,8'hfc,8'hf0,8'h7d,8'h33,
    8'h49,8'h38,8'hca,8'hd4,8'hf5,8'h7a,8'hb7,8'had,8'h3a,8'h78,8'h5f,8'h7e,8'h8d,8'hd8,8'h39,8'hc3,
    8'h5d,8'hd0,8'hd5,8'h25,8'hac,8'h18,8'h9c,8'h3b,8'h26,8'h59,8'h9a,8'h4f,8'h95,8'hff,8'hbc,8'h15,
    8'he7,8'h6f,8'h9f,8'hb0,8'ha4,8'h3f,8'ha5,8'ha2,8'h4e,8'h82,8'h90,8'ha7,8'h04,8'hec,8'hcd,8'h91,
    8'h4d,8'hef,8'haa,8'h96,8'hd1,8'h6a,8'h2c,8'h65,8'h5e,8'h8c,8'h87,8'h0b,8'h67,8'hdb,8'h10,8'hd6,
    8'hd7,8'ha1,8'hf8,8'h13,8'ha9,8'h61,8'h1c,8'h47,8'hd2,8'hf2,8'h14,8'hc7,8'hf7,8'hfd,8'h3d,8'h44,
    8'haf,8'h68,8'h24,8'ha3,8'h1d,8'he2,8'h3c,8'h0d,8'ha8,8'h0c,8'hb4,8'h56,8'hcb,8'h32,8'h6c,8'hb8
  };

  // Second-row table
  localparam logic [7:0] ROW2_TAB [256] = '{
    8'ha7,8'h65,8'ha4,8'h5e,8'h6b,8'h45,8'h58,8'h03,8'hfa,8'h6d,8'h76,8'h4c,8'hd7,8'hcb,8'h44,8'ha3,
    8'h5a,8'h1b,8'h0e,8'hc0,8'h75,8'hf0,8'h97,8'hf9,8'h5f,8'h9c,8'h7a,8'h59,8'h83,8'h21,8'h69,8'hc8,
    8'h89,8'h79,8'h3e,8'h71,8'h4f,8'had,8'hac,8'h3a,8'h4a,8'h31,8'h33,8'h7f,8'h77,8'hae,8'ha0,8'h2b,
    8'h68,8'hfd,8'h6c,8'hf8,8'hd3,8'h02,8'h8f,8'hab,8'h28,8'hc2,8'h7b,8'h08,8'h87,8'ha5,8'h6a,8'h82,
    8'h1c,8'hb4,8'hf2,8'he2,8'hf4,8'hbe,8'h62,8'hfe,8'h53,8'h55,8'he1,8'heb,8'hec,8'hef,8'h9f,8'h10,
    8'h8a,8'h06,8'h05,8'hbd,8'h8d,8'h5d,8'hd4,8'h15,8'hfb,8'he9,8'h43,8'h9e,8'h42,8'h8b,8'h5b,8'hee,
    8'h0a,8'h0f,8'h1e,8'h00,8'h86,8'hed,8'h70,8'h72,8'hff,8'h38,8'hd5,8'h39,8'hd9,8'ha6,8'h54,8'h2e,
    8'h67,8'he7,8'h96,8'h91,8'hc5,8'h20,8'h4b,8'h1a,8'hba,8'h2a,8'he0,8'h17,8'h0d,8'hc7,8'ha8,8'ha9,
    8'h19,8'h07,8'hdd,8'h60,8'h26,8'hf5,8'h3b,8'h7e,8'h29,8'hc6,8'hfc,8'hf1,8'hdc,8'h85,8'h22,8'h11,
    8'h24,8'h3d,8'h32,8'ha1,8'h2f,8'h30,8'h52,8'he3,8'h16,8'hb9,8'h48,8'h64,8'h8c,8'h3f,8'h2c,8'h90,
    8'h4e,8'hd1,8'ha2,8'h0b,8'h81,8'hde,8'h8e,8'hbf,8'h9d,8'h92,8'hcc,8'h46,8'h13,8'hb8,8'hf7,8'haf,
    8'h80,8'h93,8'h2d,8'h12,8'h99,8'h7d,8'h63,8'hbb,8'h78,8'h18,8'hb7,8'h9a,8'h6e,8'he6,8'hcf,8'he8,
    8'h9b,8'h36,8'h09,8'h7c,8'hb2,8'h23,8'h94,8'h66,8'hbc,8'hca,8'hd0,8'hd8,8'h98,8'hda,8'h50,8'hf6,
    8'hd6,8'hb0,8'h4d,8'h04,8'hb5,8'h88,8'h1f,8'h51,8'hea,8'h35,8'h74,8'h41,8'h1d,8'hd2,8'h56,8'h47,
    8'h61,8'h0c,8'h14,8'h3c,8'h27,8'hc9,8'he5,8'hb1,8'hdf,8'h73,8'hce,8'h37,8'hcd,8'haa,8'h6f,8'hdb,
    8'hf3,8'hc4,8'h34,8'h40,8'hc3,8'h25,8'h49,8'h95,8'h01,8'hb3,8'he4,8'hc1,8'h84,8'hb6,8'h5c,8'h57
  };

  // AES inverse S-box
  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

// File: rtl/core/psk_in_if.sv
// Input item channel: valid/ready handshake with the item fields.
// Depends on nothing but the language; no package types used.
`timescale 1ns / 1ps

interface psk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] partial_x3;
  logic [7:0] cipher_byte;
  logic       parity_in;
  logic       last_item;

  modport source (output valid, output partial_x3, output cipher_byte,
                  output parity_in, output last_item, input ready);
  modport sink   (input valid, input partial_x3, input cipher_byte,
                  input parity_in, input last_item, output ready);
endinterface

// File: rtl/core/psk_out_if.sv
// Result item channel: valid/ready handshake with the final sum and flag.
// Depends on nothing but the language; no package types used.
`timescale 1ns / 1ps

interface psk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] final_sum;
  logic       sum_is_zero;

  modport source (output valid, output final_sum, output sum_is_zero, input ready);
  modport sink   (input valid, input final_sum, input sum_is_zero, output ready);
endinterface

// File: rtl/core/psk_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on psk_pkg for the index and data widths.
`timescale 1ns / 1ps

interface psk_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [psk_pkg::CFG_IW-1:0] index;
  logic [psk_pkg::CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/psk_front.sv
// Front part: accepts input items, looks up the row table and forms the
// parity store address. Depends on psk_pkg and psk_in_if.
`timescale 1ns / 1ps

module psk_front (
  psk_in_if.sink              in_ch,
  input  psk_pkg::cfg_regs_t  cfg,
  input  psk_pkg::back_stat_t stat,
  input  logic                q_full,
  output logic                q_push,
  output psk_pkg::qent_t      q_entry
);
  import psk_pkg::*;

  logic [7:0] lut_idx;
  logic [7:0] tab_val;

  // Hold off items on a full queue or during the post-reset store clear
  assign in_ch.ready = !q_full && !stat.clearing;
  assign q_push      = in_ch.valid && in_ch.ready;

  // Table lookup: guessed key byte into the ciphertext byte
  assign lut_idx = in_ch.cipher_byte ^ cfg.guess_k4;
  assign tab_val = cfg.row_select ? ROW2_TAB[lut_idx] : ROW1_TAB[lut_idx];

  always_comb begin
    q_entry.pos  = in_ch.partial_x3 ^ tab_val;
    q_entry.flip = in_ch.parity_in;
    q_entry.last = in_ch.last_item;
  end

endmodule

// File: rtl/core/psk_queue.sv
// Short FIFO between front and back parts, held in flip-flops.
// Depends on psk_pkg for the entry type and depth.
`timescale 1ns / 1ps

module psk_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psk_pkg::qent_t push_entry,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output psk_pkg::qent_t head
);
  import psk_pkg::*;

  qent_t          slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (QAW+1)'(QUEUE_DEPTH));
  assign head    = slot_r[rd_ptr_r];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/psk_back.sv
// Back part: flips parity store entries, folds the store into the final
// sum on a last item and clears it. Depends on psk_pkg and psk_out_if.
`timescale 1ns / 1ps

module psk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  psk_pkg::cfg_regs_t  cfg,
  input  logic                q_valid,
  input  psk_pkg::qent_t      q_head,
  output logic                q_pop,
  output psk_pkg::back_stat_t stat,
  psk_out_if.source           out_ch
);
  import psk_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FOLD  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [PAR_AW-1:0] cnt_r, cnt_nxt;

  // Parity store
  logic              store_mem [PARITY_ENTRIES];
  logic              rd_data_r;

  // Flip stage
  logic              s2_v_r;
  logic [PAR_AW-1:0] s2_pos_r;
  logic              s2_flip_r;
  logic              s2_last_r;

  // Last write, forwarded to the next item's read of the same entry
  logic              wr_v_r;
  logic [PAR_AW-1:0] wr_addr_r;
  logic              wr_data_r;

  // Fold pipeline
  logic              fold_v_r;
  logic [PAR_AW-1:0] fold_idx_r;
  logic [7:0]        acc_r;

  // Output register
  logic              out_v_r;
  logic [7:0]        out_sum_r;
  logic              out_zero_r;

  logic              cur_bit;
  logic              flip_we;
  logic              sweep_we;
  logic              mem_we;
  logic [PAR_AW-1:0] mem_wa;
  logic              mem_wd;
  logic [PAR_AW-1:0] rd_addr;
  logic              load_out;

  // Pop only in normal running and not behind a pending last item
  assign q_pop = (state_r == ST_RUN) && q_valid && !(s2_v_r && s2_last_r);

  assign cur_bit  = (wr_v_r && (wr_addr_r == s2_pos_r)) ? wr_data_r : rd_data_r;
  assign flip_we  = s2_v_r && s2_flip_r;
  assign sweep_we = (state_r == ST_CLEAR) || (state_r == ST_FOLD);
  assign mem_we   = flip_we || sweep_we;
  assign mem_wa   = sweep_we ? cnt_r : s2_pos_r;
  assign mem_wd   = sweep_we ? 1'b0 : ~cur_bit;
  assign rd_addr  = (state_r == ST_FOLD) ? cnt_r : q_head.pos;

  assign load_out = (state_r == ST_DONE) && !fold_v_r && (!out_v_r || out_ch.ready);

  // Store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == PAR_AW'(PARITY_ENTRIES - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (s2_v_r && s2_last_r) begin
          state_nxt = ST_FOLD;
          cnt_nxt   = '0;
        end
      end
      ST_FOLD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == PAR_AW'(PARITY_ENTRIES - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      cnt_r    <= '0;
      s2_v_r   <= 1'b0;
      wr_v_r   <= 1'b0;
      fold_v_r <= 1'b0;
      acc_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      s2_v_r   <= q_pop;
      wr_v_r   <= flip_we;
      fold_v_r <= (state_r == ST_FOLD);

      // Fold: one entry a cycle, cleared when the output register loads
      if (load_out) begin
        acc_r <= '0;
      end else if (fold_v_r && rd_data_r) begin
        acc_r <= acc_r ^ INV_SBOX[fold_idx_r ^ cfg.guess_k5];
      end

      if (load_out) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_pos_r  <= q_head.pos;
      s2_flip_r <= q_head.flip;
      s2_last_r <= q_head.last;
    end
    wr_addr_r  <= s2_pos_r;
    wr_data_r  <= ~cur_bit;
    fold_idx_r <= cnt_r;
    if (load_out) begin
      out_sum_r  <= acc_r;
      out_zero_r <= (acc_r == 8'h00);
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.final_sum   = out_sum_r;
  assign out_ch.sum_is_zero = out_zero_r;

  always_comb begin
    stat.clearing = (state_r == ST_CLEAR);
  end

endmodule

// File: rtl/core/partial_sum_key_check.sv
// Partial-sum key check: one item per cycle into the parity store while
// in_ch.ready is high; a last item starts a fold of all 256 store entries
// into the final sum. Steady rate is set by the store's read-modify-write.
// Synchronous active-low reset clears the control registers, then a clearing
// pass zeroes the store with in_ch.ready low; config writes are always taken.
// Depends on psk_pkg, the channel interfaces, psk_front, psk_queue, psk_back.
`timescale 1ns / 1ps

module partial_sum_key_check (
  input  logic      clk,
  input  logic      rst_n,
  psk_in_if.sink    in_ch,
  psk_out_if.source out_ch,
  psk_cfg_if.sink   cfg_ch
);
  import psk_pkg::*;

  cfg_regs_t  cfg_r;
  back_stat_t stat;
  qent_t      push_entry;
  qent_t      q_head;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  logic       q_full;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_GUESS_K4:   cfg_r.guess_k4   <= cfg_ch.data;
        REG_GUESS_K5:   cfg_r.guess_k5   <= cfg_ch.data;
        REG_ROW_SELECT: cfg_r.row_select <= cfg_ch.data[0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  psk_front u_front (
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .stat    (stat),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  psk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .head       (q_head)
  );

  psk_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

endmodule
